// ===== design/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared types and constants for the two-class priority ring queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // built queue depth, the count width derived from it, and fixed widths
    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int VALUE_W = 10;
    localparam int STAT_W  = 2;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    // input command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // classified operation kinds
    typedef enum logic [1:0] {
        OP_PUSH_TAIL   = 2'd0,
        OP_PUSH_URGENT = 2'd1,
        OP_POP         = 2'd2
    } op_kind_t;

    // one held queue entry
    typedef struct packed {
        logic               stop;
        logic               urgent;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // classified operation passed from front to back
    typedef struct packed {
        op_kind_t kind;
        entry_t   entry;
    } op_t;

    // one result transaction
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        entry_t             entry;
        logic [CNT_W-1:0]   occupancy;
    } result_t;

endpackage

// ===== design/tcpq_front.sv =====
// ----------------------------------------------------------------------------
// tcpq_front
// accepts input transactions and classifies them into queue operations
// ----------------------------------------------------------------------------
module tcpq_front
    import tcpq_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [VALUE_W-1:0] item_value,
    input  logic               item_urgent,
    input  logic               item_stop,
    input  logic               cq_full,
    output logic               cq_push,
    output op_t                cq_op
);

    // stall while the command queue has no room
    assign in_stall = cq_full;
    assign cq_push  = in_valid & ~cq_full;

    // classify: pop; stop markers and normal items to tail, rest urgent push
    always_comb
    begin
        cq_op.entry.value  = item_value;
        cq_op.entry.urgent = item_urgent;
        cq_op.entry.stop   = item_stop;
        if (command == CMD_POP)
        begin
            cq_op.kind = OP_POP;
        end
        else if (item_urgent && !item_stop)
        begin
            cq_op.kind = OP_PUSH_URGENT;
        end
        else
        begin
            cq_op.kind = OP_PUSH_TAIL;
        end
    end

endmodule

// ===== design/tcpq_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tcpq_cmd_queue
// two-entry queue of classified operations between front and back
// ----------------------------------------------------------------------------
module tcpq_cmd_queue
    import tcpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic pop,
    output logic full,
    output logic not_empty,
    input  op_t  wr_op,
    output op_t  rd_op
);

    op_t        mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign do_push = push & (cnt_reg != 2'd2);
    assign do_pop  = pop & (cnt_reg != 2'd0);

    // status back to the two sides
    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);

    assign rd_op = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

// ===== design/tcpq_back.sv =====
// ----------------------------------------------------------------------------
// tcpq_back
// row of queue cells in head-first order, carries out push and pop
// ----------------------------------------------------------------------------
module tcpq_back
    import tcpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CAP_W-1:0] cfg_write_data,
    input  logic             op_avail,
    input  op_t              op,
    output logic             op_take,
    output logic             res_valid,
    input  logic             res_stall,
    output result_t          res
);

    entry_t           cell_reg [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;

    logic             full, empty, do_push, do_pop;
    logic [DEPTH-1:0] live, urg_live, ge_pos;

    // take an available operation whenever the result register is empty or being drained
    assign op_take = op_avail & (~res_valid_reg | ~res_stall);
    assign full    = (count_reg >= cap_reg);
    assign empty   = (count_reg == '0);
    assign do_push = op_take & (op.kind != OP_POP) & ~full;
    assign do_pop  = op_take & (op.kind == OP_POP) & ~empty;

    // per-cell flags: held entries and held urgent entries
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            live[j]     = (CNT_W'(j) < count_reg);
            urg_live[j] = live[j] & cell_reg[j].urgent;
        end
    end

    // cells at or beyond the insertion point
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            if (op.kind == OP_PUSH_URGENT)
            begin
                ge_pos[j] = ~|(urg_live & ({DEPTH{1'b1}} << j));
            end
            else
            begin
                ge_pos[j] = ~live[j];
            end
        end
    end

    // cell row: shift towards the head on pop, open a gap on push
    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (do_pop)
            begin
                if (j < DEPTH - 1)
                begin
                    cell_reg[j] <= cell_reg[(j + 1) % DEPTH];
                end
            end
            else if (do_push && ge_pos[j])
            begin
                if (j == 0)
                begin
                    cell_reg[j] <= op.entry;
                end
                else if (!ge_pos[(j + DEPTH - 1) % DEPTH])
                begin
                    cell_reg[j] <= op.entry;
                end
                else
                begin
                    cell_reg[j] <= cell_reg[(j + DEPTH - 1) % DEPTH];
                end
            end
        end
    end

    // count, capacity and result
    always_comb
    begin
        count_next     = count_reg;
        cap_next       = cap_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (cfg_write_en)
        begin
            count_next = '0;
            priority if (cfg_write_data == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (CNT_W'(cfg_write_data) > CNT_W'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = CNT_W'(cfg_write_data);
            end
        end
        else if (op_take)
        begin
            res_valid_next = 1'b1;
            res_next.entry = '0;
            res_next.status = STATUS_DONE;
            if (op.kind == OP_POP)
            begin
                if (empty)
                begin
                    res_next.status = STATUS_EMPTY;
                end
                else
                begin
                    res_next.entry = cell_reg[0];
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            else
            begin
                if (full)
                begin
                    res_next.status = STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            res_next.occupancy = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/two_class_priority_ring_queue.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_ring_queue: an input passes the command queue, then the
// result register; throughput one transaction per cycle while out_stall is low
// reset empties the queue and sets capacity to 16, no clearing pass
// ----------------------------------------------------------------------------
module two_class_priority_ring_queue
    import tcpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CAP_W-1:0]   cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [VALUE_W-1:0] item_value,
    input  logic               item_urgent,
    input  logic               item_stop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_urgent,
    output logic               out_stop,
    output logic [CNT_W-1:0]   occupancy
);

    logic     cq_full, cq_not_empty;
    op_t      front_op, back_op;
    logic     front_push, back_take;
    result_t  res;

    // front: accept and classify
    tcpq_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .item_value  (item_value),
        .item_urgent (item_urgent),
        .item_stop   (item_stop),
        .cq_full     (cq_full),
        .cq_push     (front_push),
        .cq_op       (front_op)
    );

    // command queue between the parts
    tcpq_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .pop       (back_take),
        .full      (cq_full),
        .not_empty (cq_not_empty),
        .wr_op     (front_op),
        .rd_op     (back_op)
    );

    // back: cell row and result register
    tcpq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .op_avail       (cq_not_empty),
        .op             (back_op),
        .op_take        (back_take),
        .res_valid      (out_valid),
        .res_stall      (out_stall),
        .res            (res)
    );

    assign status     = res.status;
    assign out_value  = res.entry.value;
    assign out_urgent = res.entry.urgent;
    assign out_stop   = res.entry.stop;
    assign occupancy  = res.occupancy;

endmodule
